// File: rtl/core/pcbd_pkg.sv
// Package for the prefix code bit decoder: sizes, controller states, command and status types, table address function.
`default_nettype none

package pcbd_pkg;

    localparam int MAX_CODE_LEN = 12;
    localparam int CODE_W       = 12;
    localparam int LEN_W        = 4;
    localparam int SYM_W        = 8;
    localparam int ADDR_W       = MAX_CODE_LEN + 1;
    localparam int TABLE_DEPTH  = 1 << ADDR_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic clr_wr;     // write zero at the sweep address
        logic load_wr;    // table load from the input item
        logic dec_start;  // append bit, issue table read
        logic out_load;   // capture hit or error into output register
        logic acc_clear;  // drop the accumulated code
    } t_cmd;

    typedef struct packed {
        logic clr_last;   // sweep address at last entry
        logic hit;        // read data holds a symbol
        logic at_max;     // accumulated code at maximum length
        logic out_free;   // output register empty or drained this cycle
    } t_stat;

    // Table address of a code: length marker bit above the code bits.
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [LEN_W-1:0] len,
                                                     input logic [CODE_W-1:0] code);
        logic [ADDR_W-1:0] marker;
        logic [ADDR_W-1:0] mask;
        marker = ADDR_W'(1) << len;
        mask   = marker - ADDR_W'(1);
        return marker | (ADDR_W'(code) & mask);
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/pcbd_ctrl.sv
// Controller state machine for the prefix code bit decoder.
`default_nettype none

module pcbd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic          i_func,
    input  pcbd_pkg::t_stat    i_stat,
    output logic               o_stall,
    output pcbd_pkg::t_cmd     o_cmd
);

    pcbd_pkg::t_state r_state;
    pcbd_pkg::t_state n_state;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pcbd_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        accept  = 1'b0;
        unique case (r_state)
            pcbd_pkg::ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = pcbd_pkg::ST_IDLE;
                end
            end
            pcbd_pkg::ST_IDLE: begin
                o_stall = !i_stat.out_free;
                accept  = i_valid && i_stat.out_free;
                if (accept) begin
                    if (i_func) begin
                        o_cmd.dec_start = 1'b1;
                        n_state         = pcbd_pkg::ST_LOOKUP;
                    end else begin
                        o_cmd.load_wr = 1'b1;
                    end
                end
            end
            pcbd_pkg::ST_LOOKUP: begin
                // result or error ends the code
                if (i_stat.hit || i_stat.at_max) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.acc_clear = 1'b1;
                end
                n_state = pcbd_pkg::ST_IDLE;
            end
            default: begin
                n_state = pcbd_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/pcbd_dp.sv
// Datapath for the prefix code bit decoder: code table, accumulator, output register.
`default_nettype none

module pcbd_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  pcbd_pkg::t_cmd                    i_cmd,
    input  wire logic                         i_new_string,
    input  wire logic                         i_bit_req,
    input  wire logic [pcbd_pkg::LEN_W-1:0]   i_entry_len,
    input  wire logic [pcbd_pkg::CODE_W-1:0]  i_entry_code,
    input  wire logic [pcbd_pkg::SYM_W-1:0]   i_entry_symbol,
    input  wire logic                         i_stall,
    output pcbd_pkg::t_stat                   o_stat,
    output logic                              o_valid,
    output logic [pcbd_pkg::SYM_W-1:0]        o_symbol,
    output logic                              o_code_error
);

    logic [pcbd_pkg::SYM_W-1:0]  mem [pcbd_pkg::TABLE_DEPTH];
    logic [pcbd_pkg::SYM_W-1:0]  r_rd_data;
    logic [pcbd_pkg::ADDR_W-1:0] r_clr_addr;
    logic [pcbd_pkg::CODE_W-1:0] r_acc_code;
    logic [pcbd_pkg::LEN_W-1:0]  r_acc_len;
    logic                        r_out_valid;
    logic [pcbd_pkg::SYM_W-1:0]  r_out_sym;
    logic                        r_out_err;

    logic [pcbd_pkg::CODE_W-1:0] base_code;
    logic [pcbd_pkg::LEN_W-1:0]  base_len;
    logic [pcbd_pkg::CODE_W-1:0] n_acc_code;
    logic [pcbd_pkg::LEN_W-1:0]  n_acc_len;
    logic                        len_ok;
    logic                        wr_en;
    logic [pcbd_pkg::ADDR_W-1:0] wr_addr;
    logic [pcbd_pkg::SYM_W-1:0]  wr_data;
    logic                        hit;

    always_comb begin
        base_code  = i_new_string ? '0 : r_acc_code;
        base_len   = i_new_string ? '0 : r_acc_len;
        n_acc_code = (base_code << 1) | pcbd_pkg::CODE_W'(i_bit_req);
        n_acc_len  = base_len + pcbd_pkg::LEN_W'(1);
        len_ok     = (i_entry_len != '0) &&
                     (i_entry_len <= pcbd_pkg::LEN_W'(pcbd_pkg::MAX_CODE_LEN));
        wr_en      = i_cmd.clr_wr || (i_cmd.load_wr && len_ok);
        wr_addr    = i_cmd.clr_wr ? r_clr_addr
                                  : pcbd_pkg::entry_addr(i_entry_len, i_entry_code);
        wr_data    = i_cmd.clr_wr ? '0 : i_entry_symbol;
        hit        = (r_rd_data != '0);
    end

    // table: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_cmd.dec_start) begin
            r_rd_data <= mem[pcbd_pkg::entry_addr(n_acc_len, n_acc_code)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_acc_code  <= '0;
            r_acc_len   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + pcbd_pkg::ADDR_W'(1);
            end
            if (i_cmd.dec_start) begin
                r_acc_code <= n_acc_code;
                r_acc_len  <= n_acc_len;
            end else if (i_cmd.acc_clear) begin
                r_acc_code <= '0;
                r_acc_len  <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sym <= hit ? r_rd_data : '0;
            r_out_err <= !hit;
        end
    end

    always_comb begin
        o_stat.clr_last = (r_clr_addr == pcbd_pkg::ADDR_W'(pcbd_pkg::TABLE_DEPTH - 1));
        o_stat.hit      = hit;
        o_stat.at_max   = (r_acc_len >= pcbd_pkg::LEN_W'(pcbd_pkg::MAX_CODE_LEN));
        o_stat.out_free = !r_out_valid || !i_stall;
    end

    assign o_valid      = r_out_valid;
    assign o_symbol     = r_out_sym;
    assign o_code_error = r_out_err;

endmodule

`default_nettype wire

// File: rtl/core/prefix_code_bit_decoder.sv
// Top level of the bit-serial prefix code decoder: controller plus datapath.
//
// Usage:
//   Input channel i_valid / o_stall carries one item per handshake. i_func = 0
//   loads a table entry (i_entry_len, i_entry_code, i_entry_symbol; symbol 0
//   removes the entry, lengths of 0 or above 12 are dropped). i_func = 1
//   decodes one bit i_bit_req; i_new_string first drops leftover code bits.
//   Output channel o_valid / i_stall carries o_symbol and o_code_error: one
//   item when a code matches, or an error item (symbol 0) once 12 bits gave
//   no match.
// Timing:
//   A load is written to the table when it is accepted. A decode bit is accepted
//   and its table read issued, then checked for a hit; a result is valid in the
//   output register on the cycle after that. The next bit's table address needs
//   this bit's hit or miss, so the next bit waits for this lookup on the single read port.
// Reset:
//   After reset the 8192-entry table is swept to zero, one entry a cycle;
//   o_stall stays high until the sweep is done.
// Back-pressure:
//   The output register holds its item while i_stall is high; a new item is
//   taken only once the output register is empty or draining.
`default_nettype none

module prefix_code_bit_decoder (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire logic                         i_func,
    input  wire logic                         i_new_string,
    input  wire logic                         i_bit_req,
    input  wire logic [pcbd_pkg::LEN_W-1:0]   i_entry_len,
    input  wire logic [pcbd_pkg::CODE_W-1:0]  i_entry_code,
    input  wire logic [pcbd_pkg::SYM_W-1:0]   i_entry_symbol,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic [pcbd_pkg::SYM_W-1:0]        o_symbol,
    output logic                              o_code_error
);

    pcbd_pkg::t_cmd  cmd;
    pcbd_pkg::t_stat stat;

    // sequencing: clear sweep, accept, lookup
    pcbd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_func  (i_func),
        .i_stat  (stat),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // table, accumulator and output register
    pcbd_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_new_string   (i_new_string),
        .i_bit_req      (i_bit_req),
        .i_entry_len    (i_entry_len),
        .i_entry_code   (i_entry_code),
        .i_entry_symbol (i_entry_symbol),
        .i_stall        (i_stall),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_symbol       (o_symbol),
        .o_code_error   (o_code_error)
    );

endmodule

`default_nettype wire
